// ----- sv/ps2h_pkg.sv -----
package ps2h_pkg;

	localparam int TIMER_BITS_DEF = 24;

	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_WRITE = 2'd2;

	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_TIMEOUT = 2'd1;
	localparam logic [1:0] ERR_PARITY  = 2'd2;

	localparam logic [1:0] REG_READ_WAIT  = 2'd0;
	localparam logic [1:0] REG_WRITE_WAIT = 2'd1;
	localparam logic [1:0] REG_HOLD       = 2'd2;
	localparam logic [1:0] REG_SETUP      = 2'd3;

	localparam logic [23:0] READ_WAIT_RST  = 24'd100000;
	localparam logic [23:0] WRITE_WAIT_RST = 24'd100000;
	localparam logic [15:0] HOLD_RST       = 16'd300;
	localparam logic [15:0] SETUP_RST      = 16'd10;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] tx_byte;
		logic       clock_level;
		logic       data_level;
	} item_t;

	typedef struct packed {
		logic       clock_release;
		logic       data_release;
		logic       busy_res;
		logic       done_res;
		logic       success;
		logic [1:0] error_code;
		logic [7:0] rx_byte;
	} result_t;

endpackage

// ----- sv/ps2_host_byte_transceiver.sv -----
// Channel  Valid         Stall          Payload
// item     item_valid    item_stall     item   (item_t: request, tx byte, line samples)
// result   result_valid  result_stall   result (result_t: drives, status, rx byte)
// config   psel/penable  (pready high)  paddr, pwdata, prdata
//
// One result per item; the result is registered and appears in the cycle after the item's transfer.
// An item is taken in every cycle unless a held result is stalled.
// Line engine state updates at the item's transfer; config writes apply at once.
// Reset: idle, clock pulled low, data released, registers at their defaults.
module ps2_host_byte_transceiver
	import ps2h_pkg::*;
#(
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  item_t       item,
	output logic        result_valid,
	input  logic        result_stall,
	output result_t     result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CW = (TIMER_BITS > 24) ? TIMER_BITS : 24;

	localparam logic [3:0] PH_IDLE         = 4'd0;
	localparam logic [3:0] PH_R_WAIT_LOW   = 4'd1;
	localparam logic [3:0] PH_R_START_HIGH = 4'd2;
	localparam logic [3:0] PH_R_BIT_LOW    = 4'd3;
	localparam logic [3:0] PH_R_BIT_HIGH   = 4'd4;
	localparam logic [3:0] PH_R_PAR_LOW    = 4'd5;
	localparam logic [3:0] PH_R_PAR_HIGH   = 4'd6;
	localparam logic [3:0] PH_R_STOP_LOW   = 4'd7;
	localparam logic [3:0] PH_R_STOP_HIGH  = 4'd8;
	localparam logic [3:0] PH_W_HOLD1      = 4'd9;
	localparam logic [3:0] PH_W_HOLD2      = 4'd10;
	localparam logic [3:0] PH_W_SETUP      = 4'd11;
	localparam logic [3:0] PH_W_WAIT_LOW   = 4'd12;
	localparam logic [3:0] PH_W_BIT_HIGH   = 4'd13;
	localparam logic [3:0] PH_W_BIT_LOW    = 4'd14;
	localparam logic [3:0] PH_W_RELEASE    = 4'd15;

	logic [23:0] read_wait_q, write_wait_q;
	logic [15:0] hold_q, setup_q;

	logic [3:0]            phase_q, phase_d;
	logic [3:0]            bit_idx_q, bit_idx_d;
	logic [7:0]            shift_q, shift_d;
	logic                  par_q, par_d;
	logic [TIMER_BITS-1:0] timer_q, timer_d, timer_inc;
	logic [7:0]            rx_q, rx_d;
	logic                  clk_drv_q, clk_drv_d;
	logic                  dat_drv_q, dat_drv_d;
	logic                  done, ok;
	logic [1:0]            err;
	logic [3:0]            bit_nxt;
	logic                  wbit;
	logic                  reach_rd, reach_wr, reach_hold, reach_setup, timer_max;
	logic [CW-1:0]         timer_x;

	logic    accept, cfg_wr;
	result_t result_q;
	logic    result_valid_q;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_wait_q  <= READ_WAIT_RST;
			write_wait_q <= WRITE_WAIT_RST;
			hold_q       <= HOLD_RST;
			setup_q      <= SETUP_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_READ_WAIT:  read_wait_q  <= pwdata[23:0];
				REG_WRITE_WAIT: write_wait_q <= pwdata[23:0];
				REG_HOLD:       hold_q       <= pwdata[15:0];
				REG_SETUP:      setup_q      <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_READ_WAIT:  prdata = {8'd0, read_wait_q};
			REG_WRITE_WAIT: prdata = {8'd0, write_wait_q};
			REG_HOLD:       prdata = {16'd0, hold_q};
			REG_SETUP:      prdata = {16'd0, setup_q};
			default:        prdata = '0;
		endcase
	end

	// saturating wait counter; a limit beyond its range is met at saturation
	assign timer_max   = (timer_q == {TIMER_BITS{1'b1}});
	assign timer_inc   = timer_max ? timer_q : timer_q + 1'b1;
	assign timer_x     = CW'(timer_inc);
	assign reach_rd    = (timer_x >= CW'(read_wait_q)) || (timer_inc == {TIMER_BITS{1'b1}});
	assign reach_wr    = (timer_x >= CW'(write_wait_q)) || (timer_inc == {TIMER_BITS{1'b1}});
	assign reach_hold  = (timer_x >= CW'(hold_q)) || (timer_inc == {TIMER_BITS{1'b1}});
	assign reach_setup = (timer_x >= CW'(setup_q)) || (timer_inc == {TIMER_BITS{1'b1}});

	assign bit_nxt = bit_idx_q + 4'd1;
	assign wbit    = shift_q[bit_nxt[2:0]];

	always_comb begin
		phase_d   = phase_q;
		bit_idx_d = bit_idx_q;
		shift_d   = shift_q;
		par_d     = par_q;
		timer_d   = timer_q;
		rx_d      = rx_q;
		clk_drv_d = clk_drv_q;
		dat_drv_d = dat_drv_q;
		done      = 1'b0;
		ok        = 1'b0;
		err       = ERR_NONE;
		unique case (phase_q)
			PH_IDLE: begin
				if (item.req_type == REQ_READ || item.req_type == REQ_WRITE) begin
					clk_drv_d = 1'b1;
					dat_drv_d = 1'b1;
					timer_d   = '0;
					bit_idx_d = '0;
					if (item.req_type == REQ_READ) begin
						shift_d = '0;
						par_d   = 1'b0;
						phase_d = PH_R_WAIT_LOW;
					end else begin
						shift_d = item.tx_byte;
						par_d   = 1'b1;
						phase_d = PH_W_HOLD1;
					end
				end
			end
			PH_R_WAIT_LOW: begin
				if (!item.clock_level) begin
					phase_d = PH_R_START_HIGH;
				end else begin
					timer_d = timer_inc;
					if (reach_rd) begin
						done = 1'b1;
						err  = ERR_TIMEOUT;
					end
				end
			end
			PH_R_START_HIGH: begin
				if (item.clock_level) begin
					bit_idx_d = '0;
					shift_d   = '0;
					par_d     = 1'b0;
					phase_d   = PH_R_BIT_LOW;
				end
			end
			PH_R_BIT_LOW: begin
				if (!item.clock_level) begin
					shift_d[bit_idx_q[2:0]] = shift_q[bit_idx_q[2:0]] | item.data_level;
					par_d   = par_q ^ item.data_level;
					phase_d = PH_R_BIT_HIGH;
				end
			end
			PH_R_BIT_HIGH: begin
				if (item.clock_level) begin
					bit_idx_d = bit_nxt;
					phase_d   = bit_nxt[3] ? PH_R_PAR_LOW : PH_R_BIT_LOW;
				end
			end
			PH_R_PAR_LOW: begin
				if (!item.clock_level) begin
					if (item.data_level == par_q) begin
						done = 1'b1;
						err  = ERR_PARITY;
					end else begin
						phase_d = PH_R_PAR_HIGH;
					end
				end
			end
			PH_R_PAR_HIGH: begin
				if (item.clock_level)
					phase_d = PH_R_STOP_LOW;
			end
			PH_R_STOP_LOW: begin
				if (!item.clock_level)
					phase_d = PH_R_STOP_HIGH;
			end
			PH_R_STOP_HIGH: begin
				if (item.clock_level) begin
					rx_d = shift_q;
					done = 1'b1;
					ok   = 1'b1;
				end
			end
			PH_W_HOLD1: begin
				timer_d = timer_inc;
				if (reach_hold) begin
					clk_drv_d = 1'b0;
					timer_d   = '0;
					phase_d   = PH_W_HOLD2;
				end
			end
			PH_W_HOLD2: begin
				timer_d = timer_inc;
				if (reach_hold) begin
					dat_drv_d = 1'b0;
					timer_d   = '0;
					if (setup_q == '0) begin
						clk_drv_d = 1'b1;
						phase_d   = PH_W_WAIT_LOW;
					end else begin
						phase_d = PH_W_SETUP;
					end
				end
			end
			PH_W_SETUP: begin
				timer_d = timer_inc;
				if (reach_setup) begin
					clk_drv_d = 1'b1;
					timer_d   = '0;
					phase_d   = PH_W_WAIT_LOW;
				end
			end
			PH_W_WAIT_LOW: begin
				if (!item.clock_level) begin
					bit_idx_d = '0;
					dat_drv_d = shift_q[0];
					par_d     = par_q ^ shift_q[0];
					phase_d   = PH_W_BIT_HIGH;
				end else begin
					timer_d = timer_inc;
					if (reach_wr) begin
						done = 1'b1;
						err  = ERR_TIMEOUT;
					end
				end
			end
			PH_W_BIT_HIGH: begin
				if (item.clock_level)
					phase_d = PH_W_BIT_LOW;
			end
			PH_W_BIT_LOW: begin
				if (!item.clock_level) begin
					if (bit_idx_q[3]) begin
						dat_drv_d = 1'b1;
						phase_d   = PH_W_RELEASE;
					end else begin
						bit_idx_d = bit_nxt;
						phase_d   = PH_W_BIT_HIGH;
						if (bit_nxt[3]) begin
							dat_drv_d = par_q;
						end else begin
							dat_drv_d = wbit;
							par_d     = par_q ^ wbit;
						end
					end
				end
			end
			PH_W_RELEASE: begin
				if (item.clock_level && item.data_level) begin
					done = 1'b1;
					ok   = 1'b1;
				end
			end
			default: phase_d = PH_IDLE;
		endcase
		if (done) begin
			phase_d   = PH_IDLE;
			clk_drv_d = 1'b0;
			dat_drv_d = 1'b1;
			timer_d   = '0;
		end
	end

	assign item_stall = result_valid_q & result_stall;
	assign accept     = item_valid & ~item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			bit_idx_q <= '0;
			shift_q   <= '0;
			par_q     <= 1'b0;
			timer_q   <= '0;
			rx_q      <= '0;
			clk_drv_q <= 1'b0;
			dat_drv_q <= 1'b1;
		end else if (accept) begin
			phase_q   <= phase_d;
			bit_idx_q <= bit_idx_d;
			shift_q   <= shift_d;
			par_q     <= par_d;
			timer_q   <= timer_d;
			rx_q      <= rx_d;
			clk_drv_q <= clk_drv_d;
			dat_drv_q <= dat_drv_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (accept) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q.clock_release <= clk_drv_d;
			result_q.data_release  <= dat_drv_d;
			result_q.busy_res      <= (phase_d != PH_IDLE);
			result_q.done_res      <= done;
			result_q.success       <= ok;
			result_q.error_code    <= err;
			result_q.rx_byte       <= rx_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef ASSERT_OFF
	a_idle_inhibit: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> !clk_drv_q && dat_drv_q)
		else $error("idle without bus inhibit");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.done_res |-> !result_q.busy_res)
		else $error("finished transfer still busy");

	a_success_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.success |-> result_q.done_res
		&& result_q.error_code == ERR_NONE)
		else $error("success with error or without done");

	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid_q)
		else $error("input stalled with no held result");
`endif

endmodule
